### design/text_console_char_writer_unit_assert.svh
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define TCCW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition now implies consequence on the next edge, checked outside reset
`define TCCW_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define TCCW_ASSERT_RST(label, prop, msg)
`define TCCW_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

### design/tccw_pkg.sv
// Types and constants for the text console writer.
package tccw_pkg;

  // field widths fixed by the port format
  localparam int FUNC_W     = 2;
  localparam int CODE_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_LINE_W = 5;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // control characters
  localparam logic [CODE_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_HOLD
  } tccw_state_t;

endpackage

### design/text_console_char_writer_unit.sv
// Channel   Dir  Word layout (lsb first)                              Handshake
// in_       in   tdata: char_code[7:0], cell_index[18:8]; tuser: func  tvalid/tready
// out_      out  tdata: cursor_col, cursor_line, cell_value, did_scroll tvalid/tready
// cfg_      in   data: text_attribute[7:0]                             valid/ready
//
// Ordinary put, newline, return and read are accepted, then finish in one step that reads or rewrites at most one cell.
// Tab writes one space per cell, up to TAB_SPACES spaces, stopping at the end of the row.
// Clear writes every cell; a put that scrolls sweeps all COLS*ROWS cells, one cell a cycle through
// the single grid RAM. After reset a clearing pass over all cells zeroes the grid with in_tready
// low. One result is buffered at the output; the next word is processed while it
// waits and is held internally until the output register frees up.
module text_console_char_writer_unit #(
  parameter int COLS       = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tccw_pkg::IN_DATA_W-1:0]      in_tdata,  // char_code, cell_index
  input  logic [tccw_pkg::FUNC_W-1:0]         in_tuser,  // func
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tccw_pkg::OUT_DATA_W-1:0]     out_tdata, // col, line, cell, did_scroll
  // attribute register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tccw_pkg::ATTR_W-1:0]         cfg_data
);

  localparam int N  = COLS * ROWS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(COLS + 1);
  localparam int RW = $clog2(ROWS + 1);
  localparam int TW = $clog2(TAB_SPACES + 1);
  localparam logic [tccw_pkg::OUT_LINE_W-1:0] LAST_LINE = tccw_pkg::OUT_LINE_W'(ROWS - 1);

  tccw_pkg::tccw_state_t state_r, state_nxt;

  logic [CW-1:0]                    col_r, col_nxt;
  logic [RW-1:0]                    row_r, row_nxt;
  logic [tccw_pkg::CODE_W-1:0]      code_r, code_nxt;
  logic                             rd_ok_r, rd_ok_nxt;
  logic [TW-1:0]                    tab_n_r, tab_n_nxt;
  logic [AW-1:0]                    ptr_r, ptr_nxt;
  logic [tccw_pkg::CELL_W-1:0]      cell_r, cell_nxt;
  logic                             scr_r, scr_nxt;
  logic [tccw_pkg::ATTR_W-1:0]      attr_r;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [tccw_pkg::OUT_COL_W-1:0]   out_col_r, out_col_nxt;
  logic [tccw_pkg::OUT_LINE_W-1:0]  out_line_r, out_line_nxt;
  logic [tccw_pkg::CELL_W-1:0]      out_cell_r, out_cell_nxt;
  logic                             out_scr_r, out_scr_nxt;

  // grid RAM port
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr, mem_raddr;
  logic [tccw_pkg::CELL_W-1:0]      mem_wdata, mem_rdata;

  // input word fields
  logic [tccw_pkg::FUNC_W-1:0]      in_func;
  logic [tccw_pkg::CODE_W-1:0]      in_code;
  logic [tccw_pkg::INDEX_W-1:0]     in_idx;
  logic                             in_acc, idx_ok, rd_req;

  // decode and cursor arithmetic
  logic [AW-1:0]                    cur_addr;
  logic [CW-1:0]                    col_inc, put_col;
  logic [RW-1:0]                    put_row;
  logic                             col_end, is_lf, is_cr, is_tab, row_inc;
  logic                             tab_more, need_scroll, last, out_free, fin;
  logic [31:0]                      scr_rd;
  logic [tccw_pkg::CELL_W-1:0]      blank;

  // finishing result
  logic [CW-1:0]                    fin_col;
  logic [RW-1:0]                    fin_row;
  logic [tccw_pkg::CELL_W-1:0]      fin_cell;
  logic                             fin_scr;

  assign in_func = in_tuser;
  assign in_code = in_tdata[7:0];
  assign in_idx  = in_tdata[18:8];

  assign in_tready = (state_r == tccw_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign idx_ok = (32'(in_idx) < N);
  assign rd_req = (in_func == tccw_pkg::FUNC_READ) && idx_ok;
  assign blank  = {attr_r, tccw_pkg::CHAR_SPACE};

  // cursor position and put decode
  assign cur_addr    = AW'(32'(row_r) * COLS + 32'(col_r));
  assign col_inc     = col_r + CW'(1);
  assign col_end     = (col_inc == CW'(COLS));
  assign is_lf       = (code_r == tccw_pkg::CHAR_LF);
  assign is_cr       = (code_r == tccw_pkg::CHAR_CR);
  assign is_tab      = (code_r == tccw_pkg::CHAR_TAB);
  assign put_col     = (is_lf || is_cr || col_end) ? '0 : col_inc;
  assign row_inc     = is_lf || (!is_cr && col_end);
  assign tab_more    = is_tab && !col_end && (32'(tab_n_r) + 1 < TAB_SPACES);
  assign need_scroll = row_inc && (row_r == RW'(ROWS - 1));
  assign put_row     = need_scroll ? RW'(ROWS - 1) : (row_inc ? row_r + RW'(1) : row_r);

  // sweep control
  assign last     = (ptr_r == AW'(N - 1));
  assign scr_rd   = 32'(ptr_r) + COLS + 1;
  assign out_free = !out_tvalid_r || out_tready;

  assign fin = ((state_r == tccw_pkg::ST_PUT) && !tab_more && !need_scroll)
            || (((state_r == tccw_pkg::ST_SCROLL) || (state_r == tccw_pkg::ST_CLEAR)) && last)
            || (state_r == tccw_pkg::ST_READ)
            || (state_r == tccw_pkg::ST_HOLD);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tccw_pkg::ST_INIT: begin
        if (last) state_nxt = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            tccw_pkg::FUNC_PUT:   state_nxt = tccw_pkg::ST_PUT;
            tccw_pkg::FUNC_CLEAR: state_nxt = tccw_pkg::ST_CLEAR;
            default:              state_nxt = tccw_pkg::ST_READ;
          endcase
        end
      end
      tccw_pkg::ST_PUT: begin
        if (tab_more)         state_nxt = tccw_pkg::ST_PUT;
        else if (need_scroll) state_nxt = tccw_pkg::ST_SCROLL;
        else                  state_nxt = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_HOLD;
      end
      tccw_pkg::ST_SCROLL, tccw_pkg::ST_CLEAR: begin
        if (last) state_nxt = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_HOLD;
      end
      tccw_pkg::ST_READ, tccw_pkg::ST_HOLD: begin
        state_nxt = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_HOLD;
      end
      default: state_nxt = tccw_pkg::ST_INIT;
    endcase
  end

  // datapath, RAM port and result
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    code_nxt  = code_r;
    rd_ok_nxt = rd_ok_r;
    tab_n_nxt = tab_n_r;
    ptr_nxt   = ptr_r;
    cell_nxt  = cell_r;
    scr_nxt   = scr_r;
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = '0;
    mem_raddr = cur_addr;
    fin_col   = col_r;
    fin_row   = row_r;
    fin_cell  = '0;
    fin_scr   = 1'b0;

    case (state_r)
      tccw_pkg::ST_INIT: begin
        mem_we  = 1'b1;
        ptr_nxt = last ? '0 : ptr_r + AW'(1);
      end
      tccw_pkg::ST_IDLE: begin
        if (rd_req) mem_raddr = AW'(in_idx);
        if (in_acc) begin
          code_nxt  = in_code;
          rd_ok_nxt = rd_req;
          tab_n_nxt = '0;
          ptr_nxt   = '0;
        end
      end
      tccw_pkg::ST_PUT: begin
        // rewrite the character byte, keep the attribute
        if (!is_lf && !is_cr) begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = {mem_rdata[15:8], is_tab ? tccw_pkg::CHAR_SPACE : code_r};
        end
        // next tab cell, or first source row of a scroll
        if (tab_more) mem_raddr = cur_addr + AW'(1);
        else          mem_raddr = AW'(COLS);
        tab_n_nxt = tab_n_r + TW'(1);
        col_nxt   = put_col;
        row_nxt   = put_row;
        fin_col   = put_col;
        fin_row   = put_row;
      end
      tccw_pkg::ST_SCROLL: begin
        // copy one row up, blank the bottom row
        mem_we    = 1'b1;
        mem_wdata = (32'(ptr_r) < N - COLS) ? mem_rdata : blank;
        mem_raddr = (scr_rd < N) ? AW'(scr_rd) : '0;
        ptr_nxt   = last ? '0 : ptr_r + AW'(1);
        fin_scr   = 1'b1;
      end
      tccw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = blank;
        ptr_nxt   = last ? '0 : ptr_r + AW'(1);
      end
      tccw_pkg::ST_READ: begin
        fin_cell = rd_ok_r ? mem_rdata : '0;
      end
      tccw_pkg::ST_HOLD: begin
        fin_cell = cell_r;
        fin_scr  = scr_r;
      end
      default: ;
    endcase

    // park the result while the output word is still waiting
    if (fin) begin
      cell_nxt = fin_cell;
      scr_nxt  = fin_scr;
    end
  end

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_col_nxt    = out_col_r;
    out_line_nxt   = out_line_r;
    out_cell_nxt   = out_cell_r;
    out_scr_nxt    = out_scr_r;
    if (fin && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_col_nxt    = tccw_pkg::OUT_COL_W'(fin_col);
      out_line_nxt   = tccw_pkg::OUT_LINE_W'(fin_row);
      out_cell_nxt   = fin_cell;
      out_scr_nxt    = fin_scr;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tccw_pkg::ST_INIT;
      col_r        <= '0;
      row_r        <= '0;
      ptr_r        <= '0;
      tab_n_r      <= '0;
      rd_ok_r      <= 1'b0;
      attr_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      ptr_r        <= ptr_nxt;
      tab_n_r      <= tab_n_nxt;
      rd_ok_r      <= rd_ok_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) attr_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    cell_r     <= cell_nxt;
    scr_r      <= scr_nxt;
    out_col_r  <= out_col_nxt;
    out_line_r <= out_line_nxt;
    out_cell_r <= out_cell_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_scr_r, out_cell_r, out_line_r, out_col_r};

  // character grid
  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (N)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`include "text_console_char_writer_unit_assert.svh"

  `TCCW_ASSERT_RST(a_idle_cursor, (state_r == tccw_pkg::ST_IDLE) |-> (32'(col_r) < COLS && 32'(row_r) < ROWS), "cursor outside grid while idle")
  `TCCW_ASSERT_RST(a_idle_no_write, (state_r == tccw_pkg::ST_IDLE) |-> !mem_we, "grid written while idle")
  `TCCW_ASSERT_RST(a_scroll_word, (out_tvalid_r && out_scr_r) |-> (out_line_r == LAST_LINE && out_cell_r == '0), "scroll result not on last line")
  `TCCW_ASSERT_NEXT(a_hold_stall, state_r == tccw_pkg::ST_HOLD && !out_tready, state_r == tccw_pkg::ST_HOLD, "held result dropped under stall")

endmodule

### design/tccw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### tb/sv/tb_text_console_char_writer_unit.sv
// Self-checking testbench for the console character writer: directed and random streams.
module tb_text_console_char_writer_unit;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 5;
  localparam int CELLS      = COLS * ROWS;
  localparam int ITEM_GOAL  = 1000;
  localparam int PHASES     = 5;
  localparam int MAX_INDEX  = (1 << tccw_pkg::INDEX_W) - 1;

  // func value with no command behind it
  localparam logic [tccw_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [tccw_pkg::CELL_W-1:0] ATTR_MASK = 16'hFF00;

  typedef struct packed {
    logic [tccw_pkg::OUT_COL_W-1:0]  col;
    logic [tccw_pkg::OUT_LINE_W-1:0] line;
    logic [tccw_pkg::CELL_W-1:0]     cell_val;
    logic                            scrolled;
  } console_status_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [tccw_pkg::IN_DATA_W-1:0]  in_tdata;   // char_code, cell_index
  logic [tccw_pkg::FUNC_W-1:0]     in_tuser;   // func
  logic                            out_tvalid;
  logic                            out_tready;
  logic [tccw_pkg::OUT_DATA_W-1:0] out_tdata;  // cursor_col, cursor_line, cell_value, did_scroll
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tccw_pkg::ATTR_W-1:0]     cfg_data;

  // shadow copy of the screen and cursor
  logic [tccw_pkg::CELL_W-1:0] grid [CELLS];
  int                          cur_c;
  int                          cur_r;
  logic [tccw_pkg::ATTR_W-1:0] attr_byte;

  console_status_t status_q [$];
  int              n_words;
  int              n_mismatch;
  bit              idle_en;
  bit              stall_en;

  text_console_char_writer_unit #(
    .COLS       (COLS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void write_at_cursor(logic [tccw_pkg::CODE_W-1:0] code);
    int pos;
    pos = cur_r * COLS + cur_c;
    grid[pos] = (grid[pos] & ATTR_MASK)
              | {{(tccw_pkg::CELL_W-tccw_pkg::CODE_W){1'b0}}, code};
  endfunction

  // apply one command to the shadow screen, return the status word it reports
  function automatic console_status_t run_command(logic [tccw_pkg::FUNC_W-1:0] func,
                                                  logic [tccw_pkg::CODE_W-1:0] code,
                                                  logic [tccw_pkg::INDEX_W-1:0] idx);
    console_status_t s;
    logic [tccw_pkg::CELL_W-1:0] blank;
    int n;
    int i;
    s = '0;
    blank = {attr_byte, tccw_pkg::CHAR_SPACE};
    if (func == tccw_pkg::FUNC_PUT) begin
      if (code == tccw_pkg::CHAR_LF) begin
        cur_c = 0;
        cur_r++;
      end else if (code == tccw_pkg::CHAR_CR) begin
        cur_c = 0;
      end else if (code == tccw_pkg::CHAR_TAB) begin
        for (n = 0; n < TAB_SPACES && cur_c < COLS; n++) begin
          write_at_cursor(tccw_pkg::CHAR_SPACE);
          cur_c++;
        end
      end else begin
        write_at_cursor(code);
        cur_c++;
      end
      // wrap at row end
      if (cur_c >= COLS) begin
        cur_c = 0;
        cur_r++;
      end
      // scroll up one row, blank the bottom row
      if (cur_r >= ROWS) begin
        for (i = 0; i < CELLS - COLS; i++) grid[i] = grid[i + COLS];
        for (i = CELLS - COLS; i < CELLS; i++) grid[i] = blank;
        cur_r = ROWS - 1;
        s.scrolled = 1'b1;
      end
    end else if (func == tccw_pkg::FUNC_CLEAR) begin
      for (i = 0; i < CELLS; i++) grid[i] = blank;
    end else if (func == tccw_pkg::FUNC_READ) begin
      if (idx < CELLS) s.cell_val = grid[idx];
    end
    s.col  = tccw_pkg::OUT_COL_W'(cur_c);
    s.line = tccw_pkg::OUT_LINE_W'(cur_r);
    return s;
  endfunction

  // ---------------------------------------------------------------- driving

  // one command word; returns at the edge where it is accepted, tvalid still high
  task automatic send_word(input logic [tccw_pkg::FUNC_W-1:0] func,
                           input logic [tccw_pkg::CODE_W-1:0] code,
                           input logic [tccw_pkg::INDEX_W-1:0] idx);
    while (idle_en && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(tccw_pkg::IN_DATA_W-tccw_pkg::CODE_W-tccw_pkg::INDEX_W){1'b0}},
                  idx, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_q.push_back(run_command(func, code, idx));
    n_words++;
  endtask

  // stop sending and let every pending status word come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [tccw_pkg::ATTR_W-1:0] a);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    attr_byte = a;
  endtask

  // mostly in-range reads, some past the grid
  function automatic logic [tccw_pkg::INDEX_W-1:0] pick_index();
    if ($urandom_range(99) < 85) return tccw_pkg::INDEX_W'($urandom_range(CELLS - 1));
    return tccw_pkg::INDEX_W'($urandom_range(MAX_INDEX, CELLS));
  endfunction

  // result side backpressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= !(stall_en && $urandom_range(99) < 12);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_status(input logic [tccw_pkg::OUT_DATA_W-1:0] w);
    console_status_t got;
    console_status_t want;
    got.col      = w[tccw_pkg::OUT_COL_W-1:0];
    got.line     = w[tccw_pkg::OUT_COL_W +: tccw_pkg::OUT_LINE_W];
    got.cell_val = w[tccw_pkg::OUT_COL_W+tccw_pkg::OUT_LINE_W +: tccw_pkg::CELL_W];
    got.scrolled = w[tccw_pkg::OUT_COL_W+tccw_pkg::OUT_LINE_W+tccw_pkg::CELL_W];
    if (status_q.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("unexpected word: col=%0d line=%0d cell=%h scroll=%0b",
                 got.col, got.line, got.cell_val, got.scrolled);
    end else begin
      want = status_q.pop_front();
      if (got.col !== want.col || got.line !== want.line ||
          got.cell_val !== want.cell_val || got.scrolled !== want.scrolled) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("mismatch: exp col=%0d line=%0d cell=%h scroll=%0b, %s",
                   want.col, want.line, want.cell_val, want.scrolled,
                   $sformatf("got col=%0d line=%0d cell=%h scroll=%0b",
                             got.col, got.line, got.cell_val, got.scrolled));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_status(out_tdata);
  end

  // ---------------------------------------------------------------- tests

  // grid comes out of reset zeroed; out-of-range reads and unused func report zero
  task automatic test_reset_state();
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_word(tccw_pkg::FUNC_READ, 8'hFF, 11'(CELLS - 1));
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'(CELLS));
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'(MAX_INDEX));
    send_word(FUNC_NONE, 8'hFF, 11'(MAX_INDEX));
  endtask

  // extreme and alternating character codes, read back with attribute kept
  task automatic test_put_extremes();
    send_word(tccw_pkg::FUNC_PUT, 8'h00, 11'd0);
    send_word(tccw_pkg::FUNC_PUT, 8'hFF, 11'(MAX_INDEX));
    send_word(tccw_pkg::FUNC_PUT, 8'hAA, 11'h555);
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'd0);
    send_word(tccw_pkg::FUNC_READ, 8'h55, 11'd1);
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'd2);
  endtask

  // tab, return and newline
  task automatic test_control_chars();
    set_attribute(8'hFF);
    send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_TAB, 11'd0);
    send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_CR, 11'd0);
    send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_LF, 11'd0);
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'd3);
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'd7);
  endtask

  // clear fills with the current attribute, put keeps it
  task automatic test_clear_attr();
    send_word(tccw_pkg::FUNC_CLEAR, 8'h00, 11'd0);
    send_word(tccw_pkg::FUNC_PUT, 8'h5A, 11'd0);
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'(COLS));
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'(CELLS - 1));
    set_attribute(8'h00);
    send_word(tccw_pkg::FUNC_CLEAR, 8'hFF, 11'(MAX_INDEX));
    send_word(tccw_pkg::FUNC_READ, 8'h00, 11'(COLS));
  endtask

  // one line of text with a few reads, clears and stray words mixed in
  task automatic send_line();
    int len;
    int k;
    int r;
    len = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(20);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 6)
        send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_TAB, pick_index());
      else if (r < 14)
        send_word(tccw_pkg::FUNC_READ, tccw_pkg::CODE_W'($urandom_range(255)), pick_index());
      else if (r < 16)
        send_word(tccw_pkg::FUNC_CLEAR, tccw_pkg::CODE_W'($urandom_range(255)), pick_index());
      else if (r < 17)
        send_word(FUNC_NONE, tccw_pkg::CODE_W'($urandom_range(255)), pick_index());
      else if (r < 80)
        send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CODE_W'($urandom_range(8'h7E, 8'h20)),
                  pick_index());
      else
        send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CODE_W'($urandom_range(255)), pick_index());
    end
    // line end: return only, return plus newline, or newline
    r = $urandom_range(99);
    if (r < 30) send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_CR, pick_index());
    if (r >= 15) send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_LF, pick_index());
  endtask

  // random text in phases, attribute changed between them; one phase without idling or output stalls
  task automatic test_text_stream();
    int p;
    int goal;
    for (p = 0; p < PHASES; p++) begin
      if (p == 0)      set_attribute(8'hFF);
      else if (p == 1) set_attribute(8'h00);
      else             set_attribute(tccw_pkg::ATTR_W'($urandom_range(255)));
      idle_en  = (p != 2);
      stall_en = (p != 2);
      goal = n_words + ITEM_GOAL / PHASES;
      while (n_words < goal) send_line();
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = tccw_pkg::FUNC_PUT;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    cur_c      = 0;
    cur_r      = 0;
    attr_byte  = '0;
    n_words    = 0;
    n_mismatch = 0;
    idle_en    = 1'b1;
    stall_en   = 1'b1;
    foreach (grid[i]) grid[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_put_extremes();
    test_control_chars();
    test_clear_attr();
    test_text_stream();
    drain();

    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
